>>> hdl/cbm_pkg.sv
// package for the steering wheel button to media command block
// widths, register indexes, reset values and the result record type
// no dependencies
package cbm_pkg;

    localparam int unsigned ID_W   = 29;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TID_W  = 4;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 29;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_MODE_ID    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PHONE_ID   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_BUTTON_ID  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_AUX_VALUE  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PHONE_VAL  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_BACK_MASK  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_FWD_MASK   = 3'd6;

    // register reset values
    localparam logic [ID_W-1:0]   RST_MODE_ID   = 29'h0a114005;
    localparam logic [ID_W-1:0]   RST_PHONE_ID  = 29'h06314021;
    localparam logic [ID_W-1:0]   RST_BUTTON_ID = 29'h06354000;
    localparam logic [BYTE_W-1:0] RST_AUX_VALUE = 8'd8;
    localparam logic [BYTE_W-1:0] RST_PHONE_VAL = 8'd196;
    localparam logic [BYTE_W-1:0] RST_BACK_MASK = 8'h10;
    localparam logic [BYTE_W-1:0] RST_FWD_MASK  = 8'h08;

    // minimum data lengths per frame kind
    localparam logic [LEN_W-1:0] MIN_LEN_MODE   = 4'd5;
    localparam logic [LEN_W-1:0] MIN_LEN_PHONE  = 4'd7;
    localparam logic [LEN_W-1:0] MIN_LEN_BUTTON = 4'd2;

    // media command codes
    localparam logic CMD_BACKWARD = 1'b0;
    localparam logic CMD_FORWARD  = 1'b1;

    typedef struct packed {
        logic             command;
        logic             pressed;
        logic [TID_W-1:0] transaction_id;
        logic             last_of_run;
    } t_cmd;

endpackage

>>> hdl/cbm_frame_if.sv
// channel carrying one received CAN frame
// depends on cbm_pkg
interface cbm_frame_if;
    logic                         valid;
    logic                         ready;
    logic [cbm_pkg::ID_W-1:0]     frame_id;
    logic [cbm_pkg::LEN_W-1:0]    frame_length;
    logic [cbm_pkg::BYTE_W-1:0]   byte_zero;
    logic [cbm_pkg::BYTE_W-1:0]   byte_four;
    logic [cbm_pkg::BYTE_W-1:0]   byte_six;

    modport source (output valid, frame_id, frame_length, byte_zero, byte_four, byte_six,
                    input ready);
    modport sink   (input valid, frame_id, frame_length, byte_zero, byte_four, byte_six,
                    output ready);
endinterface

>>> hdl/cbm_cmd_if.sv
// channel carrying one media command
// depends on cbm_pkg
interface cbm_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic                        pressed;
    logic [cbm_pkg::TID_W-1:0]   transaction_id;
    logic                        last_of_run;

    modport source (output valid, command, pressed, transaction_id, last_of_run,
                    input ready);
    modport sink   (input valid, command, pressed, transaction_id, last_of_run,
                    output ready);
endinterface

>>> hdl/cbm_cfg_if.sv
// configuration write channel: register index and write data
// depends on cbm_pkg
interface cbm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [cbm_pkg::IDX_W-1:0]    index;
    logic [cbm_pkg::DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/can_button_edge_to_media_cmd.sv
// top level: turns received CAN frames into media press / release commands
// depends on cbm_pkg, cbm_frame_if, cbm_cmd_if, cbm_cfg_if
//
//  channel   direction  transaction
//  i_frame   in         one received frame (id, length, bytes 0, 4, 6)
//  o_cmd     out        one media command with transaction tag
//  i_cfg     in         one register write (index, data)
//
// a frame is registered on acceptance and decoded in the following cycle; its zero
// to two commands drop into a two-entry output queue once they fit there
// one command leaves per cycle while o_cmd.ready is high; a frame whose commands
// do not fit in the output queue's free space waits in the input register
// i_cfg is always ready; writes to unknown indexes are dropped
// synchronous active-low reset reloads the config registers and clears flags, stored buttons, tag counter and queue
// either side may stall at will: nothing is lost while o_cmd.ready is low
module can_button_edge_to_media_cmd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbm_frame_if.sink   i_frame,
    cbm_cmd_if.source   o_cmd,
    cbm_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [cbm_pkg::ID_W-1:0]   r_mode_id;
    logic [cbm_pkg::ID_W-1:0]   r_phone_id;
    logic [cbm_pkg::ID_W-1:0]   r_button_id;
    logic [cbm_pkg::BYTE_W-1:0] r_aux_value;
    logic [cbm_pkg::BYTE_W-1:0] r_phone_value;
    logic [cbm_pkg::BYTE_W-1:0] r_back_mask;
    logic [cbm_pkg::BYTE_W-1:0] r_fwd_mask;

    // block state
    logic                       r_aux_on;
    logic                       r_phone_on;
    logic [cbm_pkg::BYTE_W-1:0] r_prev_buttons;
    logic [cbm_pkg::TID_W-1:0]  r_next_tid;

    // input register
    logic                       r_in_valid;
    logic [cbm_pkg::ID_W-1:0]   r_in_id;
    logic [cbm_pkg::LEN_W-1:0]  r_in_len;
    logic [cbm_pkg::BYTE_W-1:0] r_in_b0;
    logic [cbm_pkg::BYTE_W-1:0] r_in_b4;
    logic [cbm_pkg::BYTE_W-1:0] r_in_b6;

    // output queue, head in slot 0
    cbm_pkg::t_cmd              r_q0;
    cbm_pkg::t_cmd              r_q1;
    logic [1:0]                 r_count;
    cbm_pkg::t_cmd              n_q0;
    cbm_pkg::t_cmd              n_q1;
    logic [1:0]                 n_count;

    // decode
    logic                       mode_hit;
    logic                       phone_hit;
    logic                       button_hit;
    logic                       back_chg;
    logic                       fwd_chg;
    logic                       back_now;
    logic                       fwd_now;
    logic [1:0]                 n_res;
    cbm_pkg::t_cmd              res0;
    cbm_pkg::t_cmd              res1;
    logic                       pop;
    logic [1:0]                 count_after_pop;
    logic                       consume;
    cbm_pkg::t_cmd              shifted0;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_id     <= cbm_pkg::RST_MODE_ID;
            r_phone_id    <= cbm_pkg::RST_PHONE_ID;
            r_button_id   <= cbm_pkg::RST_BUTTON_ID;
            r_aux_value   <= cbm_pkg::RST_AUX_VALUE;
            r_phone_value <= cbm_pkg::RST_PHONE_VAL;
            r_back_mask   <= cbm_pkg::RST_BACK_MASK;
            r_fwd_mask    <= cbm_pkg::RST_FWD_MASK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cbm_pkg::CFG_MODE_ID:   r_mode_id     <= i_cfg.data;
                cbm_pkg::CFG_PHONE_ID:  r_phone_id    <= i_cfg.data;
                cbm_pkg::CFG_BUTTON_ID: r_button_id   <= i_cfg.data;
                cbm_pkg::CFG_AUX_VALUE: r_aux_value   <= i_cfg.data[cbm_pkg::BYTE_W-1:0];
                cbm_pkg::CFG_PHONE_VAL: r_phone_value <= i_cfg.data[cbm_pkg::BYTE_W-1:0];
                cbm_pkg::CFG_BACK_MASK: r_back_mask   <= i_cfg.data[cbm_pkg::BYTE_W-1:0];
                cbm_pkg::CFG_FWD_MASK:  r_fwd_mask    <= i_cfg.data[cbm_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    // mode test wins over phone test, which wins over the button test;
    // a frame too short for one test falls through to the next
    assign mode_hit   = (r_in_id == r_mode_id) && (r_in_len >= cbm_pkg::MIN_LEN_MODE);
    assign phone_hit  = !mode_hit && (r_in_id == r_phone_id)
                        && (r_in_len >= cbm_pkg::MIN_LEN_PHONE);
    assign button_hit = !mode_hit && !phone_hit && (r_in_id == r_button_id)
                        && (r_in_len >= cbm_pkg::MIN_LEN_BUTTON) && r_aux_on && !r_phone_on;

    // edges under each mask against the stored button byte
    assign back_chg = |((r_in_b0 ^ r_prev_buttons) & r_back_mask);
    assign fwd_chg  = |((r_in_b0 ^ r_prev_buttons) & r_fwd_mask);
    assign back_now = |(r_in_b0 & r_back_mask);
    assign fwd_now  = |(r_in_b0 & r_fwd_mask);

    always_comb begin
        n_res = 2'd0;
        if (button_hit) begin
            n_res = {1'b0, back_chg} + {1'b0, fwd_chg};
        end
    end

    // first command: back if it changed, else forward
    always_comb begin
        res0.transaction_id = r_next_tid;
        if (back_chg) begin
            res0.command     = cbm_pkg::CMD_BACKWARD;
            res0.pressed     = back_now;
            res0.last_of_run = !fwd_chg;
        end else begin
            res0.command     = cbm_pkg::CMD_FORWARD;
            res0.pressed     = fwd_now;
            res0.last_of_run = 1'b1;
        end
        // second command only exists when both changed
        res1.command        = cbm_pkg::CMD_FORWARD;
        res1.pressed        = fwd_now;
        res1.transaction_id = r_next_tid + cbm_pkg::TID_W'(1);
        res1.last_of_run    = 1'b1;
    end

    // ---------------------------------------------------------------- queue
    assign pop             = o_cmd.ready && (r_count != 2'd0);
    assign count_after_pop = r_count - {1'b0, pop};
    // the registered frame moves on once its commands fit in the queue
    assign consume         = r_in_valid && ({1'b0, n_res} <= (3'd2 - {1'b0, count_after_pop}));
    assign shifted0        = pop ? r_q1 : r_q0;

    always_comb begin
        n_count = count_after_pop + (consume ? n_res : 2'd0);
        unique case (count_after_pop)
            2'd0: begin
                n_q0 = res0;
                n_q1 = res1;
            end
            2'd1: begin
                n_q0 = shifted0;
                n_q1 = res0;
            end
            default: begin
                n_q0 = shifted0;
                n_q1 = r_q1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_cmd.valid          = (r_count != 2'd0);
    assign o_cmd.command        = r_q0.command;
    assign o_cmd.pressed        = r_q0.pressed;
    assign o_cmd.transaction_id = r_q0.transaction_id;
    assign o_cmd.last_of_run    = r_q0.last_of_run;

    // ---------------------------------------------------------------- input
    assign i_frame.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in_id  <= i_frame.frame_id;
            r_in_len <= i_frame.frame_length;
            r_in_b0  <= i_frame.byte_zero;
            r_in_b4  <= i_frame.byte_four;
            r_in_b6  <= i_frame.byte_six;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aux_on       <= 1'b0;
            r_phone_on     <= 1'b0;
            r_prev_buttons <= '0;
            r_next_tid     <= '0;
        end else if (consume) begin
            if (mode_hit) begin
                r_aux_on <= (r_in_b4 == r_aux_value);
            end
            if (phone_hit) begin
                r_phone_on <= (r_in_b6 == r_phone_value);
            end
            if (button_hit) begin
                r_prev_buttons <= r_in_b0;
            end
            // tag counter wraps modulo 16
            r_next_tid <= r_next_tid + cbm_pkg::TID_W'(n_res);
        end
    end

endmodule

>>> dv/cbm_media_cmd_checker.sv
`timescale 1ns / 100ps
// checker for can_button_edge_to_media_cmd: follows frame and register-write
// transactions, predicts the media commands and compares the command channel
// depends on cbm_pkg, cbm_frame_if, cbm_cmd_if and cbm_cfg_if
module cbm_media_cmd_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cbm_frame_if  i_frame,
    cbm_cmd_if    i_cmd,
    cbm_cfg_if    i_cfg,
    output int    o_pending,
    output int    o_fail_count
);
    import cbm_pkg::*;

    localparam int REPORT_CAP = 40;

    // register copies
    logic [ID_W-1:0]   mode_id_r;
    logic [ID_W-1:0]   phone_id_r;
    logic [ID_W-1:0]   button_id_r;
    logic [BYTE_W-1:0] aux_val_r;
    logic [BYTE_W-1:0] phone_val_r;
    logic [BYTE_W-1:0] back_mask_r;
    logic [BYTE_W-1:0] fwd_mask_r;

    // predicted block state
    logic              aux_on;
    logic              phone_on;
    logic [BYTE_W-1:0] prev_buttons;
    logic [TID_W-1:0]  next_tid;

    t_cmd media_cmd_q[$];
    int   fail_total = 0;

    function automatic int field_diff(input string field, input logic [3:0] want,
                                      input logic [3:0] got);
        if (want === got) return 0;
        if (fail_total < REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
        return 1;
    endfunction

    // one edge under a mask gives one press or release command
    function automatic bit button_edge(input logic [BYTE_W-1:0] now,
                                       input logic [BYTE_W-1:0] mask,
                                       input logic cmd, output t_cmd c);
        c = '0;
        if ((now & mask) == (prev_buttons & mask)) return 0;
        c.command        = cmd;
        c.pressed        = |(now & mask);
        c.transaction_id = next_tid;
        next_tid         = next_tid + TID_W'(1);
        return 1;
    endfunction

    function automatic void frame_to_cmds(input logic [ID_W-1:0] id,
                                          input logic [LEN_W-1:0] len,
                                          input logic [BYTE_W-1:0] b0, b4, b6);
        t_cmd run_q[$];
        t_cmd c;
        if (id == mode_id_r && len >= MIN_LEN_MODE) begin
            aux_on = (b4 == aux_val_r);
        end else if (id == phone_id_r && len >= MIN_LEN_PHONE) begin
            phone_on = (b6 == phone_val_r);
        end else if (id == button_id_r && len >= MIN_LEN_BUTTON && aux_on && !phone_on) begin
            if (button_edge(b0, back_mask_r, CMD_BACKWARD, c)) run_q.push_back(c);
            if (button_edge(b0, fwd_mask_r, CMD_FORWARD, c)) run_q.push_back(c);
            prev_buttons = b0;
            if (run_q.size() > 0) begin
                c = run_q.pop_back();
                c.last_of_run = 1'b1;
                run_q.push_back(c);
            end
            foreach (run_q[k]) media_cmd_q.push_back(run_q[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_cmd want;
        t_cmd got;
        if (!i_rst_n) begin
            mode_id_r    = RST_MODE_ID;
            phone_id_r   = RST_PHONE_ID;
            button_id_r  = RST_BUTTON_ID;
            aux_val_r    = RST_AUX_VALUE;
            phone_val_r  = RST_PHONE_VAL;
            back_mask_r  = RST_BACK_MASK;
            fwd_mask_r   = RST_FWD_MASK;
            aux_on       = 1'b0;
            phone_on     = 1'b0;
            prev_buttons = '0;
            next_tid     = '0;
            media_cmd_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_MODE_ID:   mode_id_r   = i_cfg.data[ID_W-1:0];
                    CFG_PHONE_ID:  phone_id_r  = i_cfg.data[ID_W-1:0];
                    CFG_BUTTON_ID: button_id_r = i_cfg.data[ID_W-1:0];
                    CFG_AUX_VALUE: aux_val_r   = i_cfg.data[BYTE_W-1:0];
                    CFG_PHONE_VAL: phone_val_r = i_cfg.data[BYTE_W-1:0];
                    CFG_BACK_MASK: back_mask_r = i_cfg.data[BYTE_W-1:0];
                    CFG_FWD_MASK:  fwd_mask_r  = i_cfg.data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_frame.valid && i_frame.ready)
                frame_to_cmds(i_frame.frame_id, i_frame.frame_length, i_frame.byte_zero,
                              i_frame.byte_four, i_frame.byte_six);
            if (i_cmd.valid && i_cmd.ready) begin
                got.command        = i_cmd.command;
                got.pressed        = i_cmd.pressed;
                got.transaction_id = i_cmd.transaction_id;
                got.last_of_run    = i_cmd.last_of_run;
                if (media_cmd_q.size() == 0) begin
                    if (fail_total < REPORT_CAP)
                        $error("unexpected command transaction: %p", got);
                    fail_total++;
                end else begin
                    want = media_cmd_q.pop_front();
                    fail_total += field_diff("command", 4'(want.command), 4'(got.command));
                    fail_total += field_diff("pressed", 4'(want.pressed), 4'(got.pressed));
                    fail_total += field_diff("transaction_id", want.transaction_id,
                                             got.transaction_id);
                    fail_total += field_diff("last_of_run", 4'(want.last_of_run),
                                             4'(got.last_of_run));
                end
            end
        end
        o_pending    <= media_cmd_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// testbench top for can_button_edge_to_media_cmd: clock, reset, frame and
// register-write stimulus, command back-pressure, watchdog and verdict
// depends on cbm_pkg, the channel interfaces and cbm_media_cmd_checker
module tb_top;
    import cbm_pkg::*;

    localparam int            WATCHDOG_LIMIT = 2000;
    localparam int            SETTLE_CYCLES  = 4;   // frame register + decode + queue
    localparam int            TAIL_CYCLES    = 8;
    localparam int            PAD_W          = DATA_W - BYTE_W;
    localparam logic [IDX_W-1:0] CFG_SPARE_IDX = 3'd7;  // no register behind it

    // one full register setting, also steers the stimulus towards matching frames
    typedef struct packed {
        logic [ID_W-1:0]   mode_id;
        logic [ID_W-1:0]   phone_id;
        logic [ID_W-1:0]   button_id;
        logic [BYTE_W-1:0] aux_val;
        logic [BYTE_W-1:0] phone_val;
        logic [BYTE_W-1:0] back_mask;
        logic [BYTE_W-1:0] fwd_mask;
    } t_settings;

    logic      i_clk;
    logic      i_rst_n;
    int        pending_cmds;
    int        fail_count;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        quiet_cycles = 0;
    int        cmds_seen = 0;
    int        frames_sent = 0;
    int        settings_used = 1;
    t_settings cur;

    cbm_frame_if frame_bus ();
    cbm_cmd_if   cmd_bus ();
    cbm_cfg_if   cfg_bus ();

    can_button_edge_to_media_cmd u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_bus),
        .o_cmd   (cmd_bus),
        .i_cfg   (cfg_bus)
    );

    cbm_media_cmd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (frame_bus),
        .i_cmd        (cmd_bus),
        .i_cfg        (cfg_bus),
        .o_pending    (pending_cmds),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // command receiver: random back-pressure, never ready during reset
    always @(posedge i_clk)
        cmd_bus.ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);

    // watchdog: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if (cmd_bus.valid && cmd_bus.ready) cmds_seen <= cmds_seen + 1;
        if (!i_rst_n || (frame_bus.valid && frame_bus.ready) ||
            (cmd_bus.valid && cmd_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d commands outstanding",
                     WATCHDOG_LIMIT, pending_cmds);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one frame transaction; valid stays high into the next frame unless a gap
    // is drawn, so it never sees two assignments in one step
    task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] b0, b4, b6);
        while ($urandom_range(99) < tx_idle_pct) begin
            frame_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_bus.valid        <= 1'b1;
        frame_bus.frame_id     <= id;
        frame_bus.frame_length <= len;
        frame_bus.byte_zero    <= b0;
        frame_bus.byte_four    <= b4;
        frame_bus.byte_six     <= b6;
        do @(posedge i_clk); while (!frame_bus.ready);
        frames_sent++;
    endtask

    // mostly frames that hit the configured ids with plausible lengths and
    // matching values, the rest is noise on every field
    task automatic send_random_frame();
        int                pick;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] b0, b4, b6;
        pick = $urandom_range(99);
        id   = ID_W'($urandom);
        len  = LEN_W'($urandom);
        b0   = BYTE_W'($urandom);
        b4   = BYTE_W'($urandom);
        b6   = BYTE_W'($urandom);
        if (pick < 25) begin
            id = cur.mode_id;
            if ($urandom_range(99) < 85) len = LEN_W'($urandom_range(5, 15));
            if ($urandom_range(3) != 0) b4 = cur.aux_val;
        end else if (pick < 40) begin
            id = cur.phone_id;
            if ($urandom_range(99) < 85) len = LEN_W'($urandom_range(7, 15));
            if ($urandom_range(99) < 30) b6 = cur.phone_val;
        end else if (pick < 88) begin
            id = cur.button_id;
            if ($urandom_range(1) == 0) len = LEN_W'($urandom_range(2, 4));
        end
        send_frame(id, len, b0, b4, b6);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    // byte registers get random junk above bit 7, which must be dropped
    task automatic write_byte_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        write_reg(idx, {PAD_W'($urandom), val});
    endtask

    task automatic program_regs(input t_settings s);
        write_reg(CFG_MODE_ID, s.mode_id);
        write_reg(CFG_PHONE_ID, s.phone_id);
        write_reg(CFG_BUTTON_ID, s.button_id);
        write_byte_reg(CFG_AUX_VALUE, s.aux_val);
        write_byte_reg(CFG_PHONE_VAL, s.phone_val);
        write_byte_reg(CFG_BACK_MASK, s.back_mask);
        write_byte_reg(CFG_FWD_MASK, s.fwd_mask);
        cfg_bus.valid <= 1'b0;
        cur = s;
        settings_used++;
    endtask

    // stop sending, wait for every predicted command, then idle for the given
    // number of tail cycles
    task automatic drain(input int tail);
        frame_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    initial begin
        t_settings s;
        i_rst_n                <= 1'b0;
        frame_bus.valid        <= 1'b0;
        frame_bus.frame_id     <= '0;
        frame_bus.frame_length <= '0;
        frame_bus.byte_zero    <= '0;
        frame_bus.byte_four    <= '0;
        frame_bus.byte_six     <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= '0;
        cfg_bus.data           <= '0;
        cur = '{RST_MODE_ID, RST_PHONE_ID, RST_BUTTON_ID, RST_AUX_VALUE, RST_PHONE_VAL,
                RST_BACK_MASK, RST_FWD_MASK};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first idling pattern: light sender gaps, heavy back-pressure
        tx_idle_pct = 20;
        rx_idle_pct = 59;

        // directed frames on the reset settings
        send_frame(cur.button_id, 4'd8, 8'h18, 8'h00, 8'h00);       // gated, aux off
        send_frame(cur.mode_id, 4'd4, 8'h00, cur.aux_val, 8'h00);   // mode frame too short
        send_frame(cur.button_id, 4'd8, 8'h18, 8'h00, 8'h00);       // still gated
        send_frame(cur.mode_id, 4'd5, 8'h00, cur.aux_val, 8'h00);   // aux on at min length
        send_frame(cur.button_id, 4'd1, 8'h18, 8'h00, 8'h00);       // button frame too short
        send_frame(cur.button_id, 4'd2, 8'h18, 8'h00, 8'h00);       // both pressed
        send_frame(cur.button_id, 4'd15, 8'h00, 8'h00, 8'h00);      // both released, long code
        send_frame(cur.button_id, 4'd8, 8'h10, 8'h00, 8'h00);       // back press only
        send_frame(cur.button_id, 4'd8, 8'hE7, 8'h00, 8'h00);       // back release, noise bits
        send_frame(cur.button_id, 4'd8, 8'hFF, 8'h00, 8'h00);       // both pressed
        send_frame(cur.button_id, 4'd8, 8'hFF, 8'h00, 8'h00);       // no change, no command
        send_frame(cur.phone_id, 4'd7, 8'h00, 8'h00, cur.phone_val); // phone active
        send_frame(cur.button_id, 4'd8, 8'h00, 8'h00, 8'h00);       // gated, buttons kept
        send_frame(cur.phone_id, 4'd6, 8'h00, 8'h00, cur.phone_val); // phone frame too short
        send_frame(cur.phone_id, 4'd9, 8'h00, 8'h00, 8'h00);        // phone inactive
        send_frame(cur.button_id, 4'd8, 8'h00, 8'h00, 8'h00);       // releases against 0xff
        send_frame(cur.mode_id, 4'd8, 8'h00, 8'h00, 8'h00);         // aux off
        send_frame(cur.button_id, 4'd8, 8'h18, 8'h00, 8'h00);       // gated again
        send_frame(cur.mode_id, 4'd5, 8'h00, cur.aux_val, 8'h00);   // aux back on
        send_frame(29'h1FFFFFFF, 4'd0, 8'hFF, 8'hFF, 8'hFF);        // unknown frame, all ones
        send_frame(29'h0, 4'd15, 8'h00, 8'h00, 8'h00);              // unknown frame, zeros
        send_frame(cur.button_id, 4'd3, 8'h08, 8'h00, 8'h00);       // forward press only
        repeat (400) send_random_frame();
        drain(SETTLE_CYCLES);

        // random settings, plus one write to an index with no register
        write_reg(CFG_SPARE_IDX, DATA_W'($urandom));
        s = '{ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), BYTE_W'($urandom),
              BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom)};
        program_regs(s);
        repeat (400) send_random_frame();
        drain(SETTLE_CYCLES);

        // second idling pattern: heavy sender gaps, light back-pressure
        tx_idle_pct = 59;
        rx_idle_pct = 20;

        // top extremes: mode and button share an id, equal full masks
        program_regs('{29'h1FFFFFFF, 29'h0, 29'h1FFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        repeat (350) send_random_frame();
        drain(SETTLE_CYCLES);

        // bottom extremes: every id zero, zero back mask never fires
        program_regs('{29'h0, 29'h0, 29'h0, 8'h00, 8'h00, 8'h00, 8'h80});
        repeat (300) send_random_frame();
        drain(SETTLE_CYCLES);

        // no idling; button and phone share an id so length picks the test
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        s.mode_id   = ID_W'($urandom);
        s.phone_id  = ID_W'($urandom);
        s.button_id = s.phone_id;
        s.aux_val   = BYTE_W'($urandom);
        s.phone_val = BYTE_W'($urandom);
        s.back_mask = BYTE_W'($urandom);
        s.fwd_mask  = BYTE_W'($urandom);
        program_regs(s);
        repeat (350) send_random_frame();
        drain(TAIL_CYCLES);

        $display("frames sent: %0d, commands checked: %0d, register settings: %0d",
                 frames_sent, cmds_seen, settings_used);
        $display("idling: sender/receiver gaps at 20/59, 59/20 and none");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
